>>> rtl/core/cpd_pkg.sv
// Shared word types, register indexes and reset constants for the packet deframer.
package cpd_pkg;

    // Configuration register indexes.
    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] SYNC_FIRST_RST  = 8'd170;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd175;

    // One received word: a byte or a timeout tick.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       timeout;
    } t_in_word;

    // One result word of an accepted packet.
    typedef struct packed {
        logic [7:0] msg_id;
        logic [5:0] data_len;
        logic [7:0] payload_byte;
        logic [4:0] byte_index;
        logic       last;
    } t_out_word;

endpackage

>>> rtl/core/cpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/cpd_fifo.sv
// Two-entry first-in first-out queue of generic width.
module cpd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic [1:0]       o_count
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

>>> rtl/core/cpd_front.sv
// Frame parser: sync hunt, header, payload capture and checksum check.
module cpd_front import cpd_pkg::*; #(
    parameter int MAX_PAYLOAD = 32,
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1),
    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int DESC_W = 1 + 8 + LEN_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_ram_we,
    output logic [IDX_W:0]    o_ram_waddr,
    output logic [7:0]        o_ram_wdata,
    output logic              o_desc_push,
    output logic [DESC_W-1:0] o_desc,
    input  logic              i_release
);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CHK
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_id, n_id;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_fill, n_fill;
    logic             r_bank, n_bank;
    logic [1:0]       r_pkt_cnt, n_pkt_cnt;
    logic [7:0]       r_sync1;
    logic [7:0]       r_sync2;
    logic             accept;
    logic [7:0]       c;

    // Stall in payload or checksum phase while both payload banks are held by packets awaiting readout.
    assign o_in_stall = (r_pkt_cnt == 2'd2) && ((r_phase == PH_DATA) || (r_phase == PH_CHK));
    assign accept     = i_in_valid && !o_in_stall;
    assign c          = i_in_word.rx_byte;

    // Next-state logic of the parser.
    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_id        = r_id;
        n_len       = r_len;
        n_fill      = r_fill;
        n_bank      = r_bank;
        o_ram_we    = 1'b0;
        o_desc_push = 1'b0;
        if (accept) begin
            if (i_in_word.timeout) begin
                n_phase = PH_SYNC1;
            end else begin
                case (r_phase)
                    PH_SYNC2: begin
                        n_phase = (c == r_sync2) ? PH_ID : PH_SYNC1;
                        n_sum   = r_sum + c;
                    end
                    PH_ID: begin
                        n_id    = c;
                        n_sum   = r_sum + c;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        if (c <= 8'(MAX_PAYLOAD)) begin
                            n_len   = LEN_W'(c);
                            n_fill  = '0;
                            n_sum   = r_sum + c;
                            n_phase = (c != 8'd0) ? PH_DATA : PH_CHK;
                        end else begin
                            n_phase = PH_SYNC1;
                        end
                    end
                    PH_DATA: begin
                        o_ram_we = 1'b1;
                        n_fill   = r_fill + 1'b1;
                        n_sum    = r_sum + c;
                        if (n_fill >= r_len) begin
                            n_phase = PH_CHK;
                        end
                    end
                    PH_CHK: begin
                        if (r_sum == c) begin
                            o_desc_push = 1'b1;
                            n_bank      = ~r_bank;
                        end
                        n_phase = PH_SYNC1;
                    end
                    default: begin
                        n_phase = (c == r_sync1) ? PH_SYNC2 : PH_SYNC1;
                        n_sum   = c;
                    end
                endcase
            end
        end
    end

    // Count of packets handed to readout whose payload bank is still in use.
    always_comb begin
        case ({o_desc_push, i_release})
            2'b10:   n_pkt_cnt = r_pkt_cnt + 2'd1;
            2'b01:   n_pkt_cnt = r_pkt_cnt - 2'd1;
            default: n_pkt_cnt = r_pkt_cnt;
        endcase
    end

    assign o_ram_waddr = {r_bank, r_fill[IDX_W-1:0]};
    assign o_ram_wdata = c;
    assign o_desc      = {r_bank, r_id, r_len};

    // Parser state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC1;
            r_sum     <= 8'd0;
            r_id      <= 8'd0;
            r_len     <= '0;
            r_fill    <= '0;
            r_bank    <= 1'b0;
            r_pkt_cnt <= 2'd0;
            r_sync1   <= SYNC_FIRST_RST;
            r_sync2   <= SYNC_SECOND_RST;
        end else begin
            r_phase   <= n_phase;
            r_sum     <= n_sum;
            r_id      <= n_id;
            r_len     <= n_len;
            r_fill    <= n_fill;
            r_bank    <= n_bank;
            r_pkt_cnt <= n_pkt_cnt;
            if (i_cfg_we && (i_cfg_idx == CFG_SYNC_FIRST)) begin
                r_sync1 <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_SYNC_SECOND)) begin
                r_sync2 <= i_cfg_data;
            end
        end
    end

endmodule

>>> rtl/core/cpd_back.sv
// Packet readout: walks the payload bank of each accepted packet into result words.
module cpd_back import cpd_pkg::*; #(
    parameter int MAX_PAYLOAD = 32,
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1),
    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int DESC_W = 1 + 8 + LEN_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_desc_valid,
    input  logic [DESC_W-1:0] i_desc,
    output logic              o_desc_pop,
    output logic [IDX_W:0]    o_ram_raddr,
    input  logic [7:0]        i_ram_rdata,
    output logic              o_release,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word
);

    logic             r_active;
    logic             r_bank;
    logic [7:0]       r_id;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_idx;
    logic             r_inflight;
    logic             r_fl_zero;
    t_out_word        r_fl_meta;
    logic             issue;
    logic             is_last;
    logic             out_pop;
    logic [1:0]       out_count;
    t_out_word        push_word;
    logic [$bits(t_out_word)-1:0] out_data;

    // Issue a read only when the result queue has room for it on arrival.
    assign out_pop = o_out_valid && !i_out_stall;
    assign issue   = r_active &&
                     (({1'b0, out_count} + {2'b0, r_inflight}) < (3'd2 + {2'b0, out_pop}));
    assign is_last = (r_len == '0) || (LEN_W'(r_idx + 1'b1) == r_len);

    assign o_desc_pop  = !r_active && i_desc_valid;
    assign o_ram_raddr = {r_bank, r_idx[IDX_W-1:0]};
    assign o_release   = issue && is_last;

    // Readout sequencer and read-pipeline tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_inflight <= 1'b0;
        end else begin
            r_inflight <= issue;
            if (o_desc_pop) begin
                r_active <= 1'b1;
            end else if (issue && is_last) begin
                r_active <= 1'b0;
            end
        end
    end

    // Packet header and index; payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (o_desc_pop) begin
            r_bank <= i_desc[DESC_W-1];
            r_id   <= i_desc[LEN_W +: 8];
            r_len  <= i_desc[LEN_W-1:0];
            r_idx  <= '0;
        end else if (issue) begin
            r_idx <= r_idx + 1'b1;
        end
        if (issue) begin
            r_fl_zero              <= (r_len == '0);
            r_fl_meta.msg_id       <= r_id;
            r_fl_meta.data_len     <= 6'(r_len);
            r_fl_meta.payload_byte <= 8'd0;
            r_fl_meta.byte_index   <= 5'(r_idx);
            r_fl_meta.last         <= is_last;
        end
    end

    // Merge the read data with its tag; an empty packet carries a zero byte.
    always_comb begin
        push_word              = r_fl_meta;
        push_word.payload_byte = r_fl_zero ? 8'd0 : i_ram_rdata;
    end

    cpd_fifo #(
        .WIDTH ($bits(t_out_word))
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_inflight),
        .i_data  (push_word),
        .i_pop   (out_pop),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .o_count (out_count)
    );

    assign o_out_word = t_out_word'(out_data);

endmodule

>>> rtl/core/checksummed_packet_deframer_unit.sv
// Top level: sync-header packet deframer with 8-bit additive checksum.
// Throughput: one input word per cycle unless stalled; one result word per cycle within a
// packet while the output is not stalled.
// Input stalls only in payload or checksum phase while two packets still await readout
// (the payload store holds two banks of MAX_PAYLOAD bytes).
// With readout idle, the first result word follows the accepted checksum byte through the
// header queue, the readout sequencer, the registered RAM read and the result queue.
// Reset (synchronous, active low) returns to the sync hunt and empties both queues.
module checksummed_packet_deframer_unit import cpd_pkg::*; #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word
);

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int DESC_W = 1 + 8 + LEN_W;

    logic              ram_we;
    logic [IDX_W:0]    ram_waddr;
    logic [7:0]        ram_wdata;
    logic [IDX_W:0]    ram_raddr;
    logic [7:0]        ram_rdata;
    logic              desc_push;
    logic [DESC_W-1:0] desc_in;
    logic              desc_pop;
    logic              desc_valid;
    logic [DESC_W-1:0] desc_out;
    logic [1:0]        desc_count;
    logic              release_bank;
    logic              desc_unused;

    // Parser front end.
    cpd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_desc_push (desc_push),
        .o_desc      (desc_in),
        .i_release   (release_bank)
    );

    // Two-bank payload store.
    cpd_ram #(
        .WIDTH (8),
        .DEPTH (2 << IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Queue of accepted packet headers between parser and readout.
    cpd_fifo #(
        .WIDTH (DESC_W)
    ) u_desc_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_data  (desc_in),
        .i_pop   (desc_pop),
        .o_valid (desc_valid),
        .o_data  (desc_out),
        .o_count (desc_count)
    );

    // The parser's packet count bounds the queue, so its fill level is not needed.
    assign desc_unused = ^desc_count;

    // Readout back end.
    cpd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .i_desc       (desc_out),
        .o_desc_pop   (desc_pop),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_release    (release_bank),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

endmodule

>>> tb/tb_checksummed_packet_deframer_unit.sv
// Self-checking testbench for the sync-header packet deframer with 8-bit additive checksum.
module tb_checksummed_packet_deframer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import cpd_pkg::*;

    localparam int MAX_PAYLOAD  = 32;
    localparam int IDLE_PCT     = 16;
    localparam int PHASE_ITEMS  = 80;
    localparam int NUM_PHASES   = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_NS     = 2_000_000;
    localparam int N_DIRECTED   = 26;

    // Parser phases of the shadow deframer.
    typedef enum logic [2:0] {
        HUNT_FIRST  = 3'd0,
        HUNT_SECOND = 3'd1,
        GET_ID      = 3'd2,
        GET_LEN     = 3'd3,
        GET_DATA    = 3'd4,
        GET_CHK     = 3'd5
    } t_parse_phase;

    // One word to send, with an optional hand-written expectation.
    typedef struct packed {
        t_in_word  word;
        logic      typed;
        logic      typed_hit;
        t_out_word typed_res;
    } t_feed_item;

    localparam t_out_word NO_RESULT = '0;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_idx   = CFG_SYNC_FIRST;
    logic [7:0] i_cfg_data  = 8'd0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;

    logic calm       = 1'b0;
    logic hold_armed = 1'b0;
    logic hold_on    = 1'b0;
    int   miss_count = 0;

    t_feed_item feed_q [$];
    t_out_word  expect_q [$];

    // Shadow copy of the deframer state and its sync registers.
    t_parse_phase parse_ph;
    logic [7:0]   run_sum;
    logic [7:0]   held_id;
    logic [5:0]   held_len;
    logic [5:0]   fill_idx;
    logic [7:0]   payload_mem [MAX_PAYLOAD];
    logic [7:0]   sync_a;
    logic [7:0]   sync_b;

    // Directed words: default sync bytes 0xAA, 0xAF from reset.
    t_feed_item directed_rows [N_DIRECTED] = '{
        // Zero-length packet with a good checksum.
        '{'{8'hAA, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hAF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'h05, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'h5E, 1'b0}, 1'b1, 1'b1, '{8'h05, 6'd0, 8'h00, 5'd0, 1'b1}},
        // Zero-length packet with a wrong checksum.
        '{'{8'hAA, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hAF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'h58, 1'b0}, 1'b1, 1'b0, NO_RESULT},
        // Length one above the maximum aborts the frame.
        '{'{8'hAA, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hAF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hFF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'h21, 1'b0}, 1'b1, 1'b0, NO_RESULT},
        // Timeout in the middle of a frame; its byte looks like a sync byte.
        '{'{8'hAA, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hAF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hAA, 1'b1}, 1'b1, 1'b0, NO_RESULT},
        // Second sync mismatch on a first sync byte, which is not retried.
        '{'{8'hAA, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hAA, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hAF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        // One-byte packet with all-ones id and payload.
        '{'{8'hAA, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hAF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hFF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'h01, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'hFF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
        '{'{8'h58, 1'b0}, 1'b1, 1'b1, '{8'hFF, 6'd1, 8'hFF, 5'd0, 1'b1}}
    };

    checksummed_packet_deframer_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_feed_item rx_item(logic [7:0] b, logic to);
        t_feed_item f;
        f = '0;
        f.word.rx_byte = b;
        f.word.timeout = to;
        return f;
    endfunction

    function automatic string show(t_out_word w);
        return $sformatf("id=%0d len=%0d byte=%0d idx=%0d last=%0d",
                         w.msg_id, w.data_len, w.payload_byte, w.byte_index, w.last);
    endfunction

    task automatic note_miss(string msg);
        miss_count++;
        if (miss_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Advance the shadow deframer by one word; queue packet results when asked.
    task automatic parse_word(t_in_word w, logic keep);
        t_out_word r;
        int        k;
        if (w.timeout) begin
            parse_ph = HUNT_FIRST;
        end else begin
            case (parse_ph)
                HUNT_SECOND: begin
                    parse_ph = (w.rx_byte == sync_b) ? GET_ID : HUNT_FIRST;
                    run_sum += w.rx_byte;
                end
                GET_ID: begin
                    held_id = w.rx_byte;
                    run_sum += w.rx_byte;
                    parse_ph = GET_LEN;
                end
                GET_LEN: begin
                    if (w.rx_byte <= 8'(MAX_PAYLOAD)) begin
                        held_len = w.rx_byte[5:0];
                        fill_idx = 6'd0;
                        run_sum += w.rx_byte;
                        parse_ph = (w.rx_byte != 8'd0) ? GET_DATA : GET_CHK;
                    end else begin
                        parse_ph = HUNT_FIRST;
                    end
                end
                GET_DATA: begin
                    if (fill_idx < 6'(MAX_PAYLOAD)) begin
                        payload_mem[fill_idx[4:0]] = w.rx_byte;
                    end
                    fill_idx++;
                    run_sum += w.rx_byte;
                    if (fill_idx >= held_len) begin
                        parse_ph = GET_CHK;
                    end
                end
                GET_CHK: begin
                    if (keep && run_sum == w.rx_byte) begin
                        if (held_len == 6'd0) begin
                            r = '0;
                            r.msg_id = held_id;
                            r.last   = 1'b1;
                            expect_q.push_back(r);
                        end else begin
                            for (k = 0; k < int'(held_len); k++) begin
                                r.msg_id       = held_id;
                                r.data_len     = held_len;
                                r.payload_byte = payload_mem[k];
                                r.byte_index   = 5'(k);
                                r.last         = (k + 1 == int'(held_len));
                                expect_q.push_back(r);
                            end
                        end
                    end
                    parse_ph = HUNT_FIRST;
                end
                default: begin
                    parse_ph = (w.rx_byte == sync_a) ? HUNT_SECOND : HUNT_FIRST;
                    run_sum = w.rx_byte;
                end
            endcase
        end
    endtask

    // Queue one random frame, broken frame or burst of noise; each ends back in the hunt.
    task automatic queue_chunk(output int n);
        t_feed_item seq [$];
        logic [7:0] sum;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] pb;
        int         kind;
        int         p;
        int         k;
        kind = $urandom_range(99);
        if (kind < 85) begin
            id = 8'($urandom_range(255));
            p  = $urandom_range(99);
            if (p < 8) begin
                len = 8'(MAX_PAYLOAD);
            end else if (p < 20) begin
                len = 8'd0;
            end else begin
                len = 8'($urandom_range(1, 8));
            end
            seq.push_back(rx_item(sync_a, 1'b0));
            seq.push_back(rx_item(sync_b, 1'b0));
            seq.push_back(rx_item(id, 1'b0));
            seq.push_back(rx_item(len, 1'b0));
            sum = sync_a + sync_b + id + len;
            for (k = 0; k < int'(len); k++) begin
                pb = 8'($urandom_range(255));
                sum += pb;
                seq.push_back(rx_item(pb, 1'b0));
            end
            // Some frames carry a corrupted checksum.
            if (kind >= 70 && kind < 78) begin
                sum ^= 8'($urandom_range(1, 255));
            end
            seq.push_back(rx_item(sum, 1'b0));
            // Some frames are cut short by a timeout.
            if (kind >= 78) begin
                p = $urandom_range(0, seq.size() - 1);
                while (seq.size() > p) begin
                    void'(seq.pop_back());
                end
                seq.push_back(rx_item(8'($urandom_range(255)), 1'b1));
            end
        end else if (kind < 91) begin
            // Oversized length.
            seq.push_back(rx_item(sync_a, 1'b0));
            seq.push_back(rx_item(sync_b, 1'b0));
            seq.push_back(rx_item(8'($urandom_range(255)), 1'b0));
            if ($urandom_range(1) == 0) begin
                seq.push_back(rx_item(8'(MAX_PAYLOAD + 1), 1'b0));
            end else begin
                seq.push_back(rx_item(8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b0));
            end
        end else if (kind < 96) begin
            // Second sync byte mismatch.
            if (sync_a != sync_b && $urandom_range(1) == 1) begin
                pb = sync_a;
            end else begin
                pb = 8'($urandom_range(255));
                while (pb == sync_b) begin
                    pb = 8'($urandom_range(255));
                end
            end
            seq.push_back(rx_item(sync_a, 1'b0));
            seq.push_back(rx_item(pb, 1'b0));
        end else begin
            // Noise, closed by a timeout.
            p = $urandom_range(1, 6);
            for (k = 0; k < p; k++) begin
                seq.push_back(rx_item(8'($urandom_range(255)), $urandom_range(3) == 0));
            end
            seq.push_back(rx_item(8'($urandom_range(255)), 1'b1));
        end
        n = seq.size();
        foreach (seq[k]) begin
            feed_q.push_back(seq[k]);
        end
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == CFG_SYNC_FIRST) begin
            sync_a = value;
        end else begin
            sync_b = value;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every word is taken and every result is in, then let the pipeline settle.
    task automatic drain_block();
        while (feed_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Input side: offer queued words with random gaps and predict each accepted word.
    always @(posedge i_clk) begin : feed_driver
        t_feed_item done;
        logic       moved;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            moved = i_in_valid && !o_in_stall;
            if (moved) begin
                done = feed_q.pop_front();
                if (done.typed) begin
                    parse_word(done.word, 1'b0);
                    if (done.typed_hit) begin
                        expect_q.push_back(done.typed_res);
                    end
                end else begin
                    parse_word(done.word, 1'b1);
                end
            end
            if (!i_in_valid || moved) begin
                if (feed_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= feed_q[0].word;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expect_q.size() == 0) begin
                    note_miss($sformatf("unexpected result: %s", show(o_out_word)));
                end else begin
                    want = expect_q.pop_front();
                    if (o_out_word.msg_id != want.msg_id
                            || o_out_word.data_len != want.data_len
                            || o_out_word.payload_byte != want.payload_byte
                            || o_out_word.byte_index != want.byte_index
                            || o_out_word.last != want.last) begin
                        note_miss($sformatf("mismatch: expected %s, got %s",
                                            show(want), show(o_out_word)));
                    end
                end
            end
            i_out_stall <= hold_on || (!calm && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Long receiver hold-off so that the block fills up and stalls its input.
    initial begin : hold_off
        wait (hold_armed);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // Main sequence: reset, directed words, then random phases under several sync settings.
    initial begin : main_seq
        int         p;
        int         k;
        int         n;
        int         placed;
        logic [7:0] fa;
        logic [7:0] fb;
        parse_ph = HUNT_FIRST;
        run_sum  = 8'd0;
        held_id  = 8'd0;
        held_len = 6'd0;
        fill_idx = 6'd0;
        sync_a   = SYNC_FIRST_RST;
        sync_b   = SYNC_SECOND_RST;
        foreach (payload_mem[k]) begin
            payload_mem[k] = 8'd0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++) begin
            feed_q.push_back(directed_rows[k]);
        end
        drain_block();

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                case (p)
                    1: begin
                        fa = 8'h00;
                        fb = 8'hFF;
                    end
                    2: begin
                        fa = 8'hFF;
                        fb = 8'h00;
                    end
                    3: begin
                        fa = 8'($urandom_range(255));
                        fb = 8'($urandom_range(255));
                    end
                    default: begin
                        fa = 8'h5A;
                        fb = 8'h5A;
                    end
                endcase
                write_reg(CFG_SYNC_FIRST, fa);
                write_reg(CFG_SYNC_SECOND, fb);
            end
            // One phase runs with no idling on either side.
            calm <= (p == 2);
            placed = 0;
            while (placed < PHASE_ITEMS) begin
                queue_chunk(n);
                placed += n;
            end
            if (p == 0) begin
                hold_armed <= 1'b1;
            end
            drain_block();
        end

        if (miss_count == 0 && expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
